@@ rtl/core/tcc_pkg.sv @@
// Shared types and constants for the transform chain composer.
package tcc_pkg;

  localparam int POS_FRAC_BITS_DEF = 16;
  localparam int ROT_FRAC_BITS_DEF = 30;

  typedef enum logic [3:0] {
    OP_LOAD,
    OP_SCALE,
    OP_QX,
    OP_QY,
    OP_QZ,
    OP_QW,
    OP_VX,
    OP_VY,
    OP_VZ,
    OP_TX,
    OP_TY,
    OP_TZ,
    OP_PX,
    OP_PY,
    OP_PZ
  } op_t;

  typedef struct packed {
    logic capture;
    logic mul;
    logic acc;
    logic finish;
    op_t  op;
  } cmd_t;

endpackage

@@ rtl/core/transform_chain_compose_top.sv @@
// Top level of the transform chain composer.
// Input channel: in_valid/in_stall with chain_start, pos_*, rot_*, scale_in.
// Output channel: out_valid/out_stall with the accumulated transform and
// an overflow flag; one result per request.
// A request with chain_start high loads the accumulator as a leaf; any other
// request composes its transform (parent) over the accumulator.
// A leaf load puts the request (rotation clamped) into the accumulator and
// then into the output register. A compose runs 14 steps through four shared
// 32x32 multipliers (products registered, then summed and saturated into the
// accumulator), then loads the output register. A new request is taken
// only after the previous one has loaded the output register.
// in_stall is high while a request is in work. A finished result sits in
// the output register; the next request is accepted while it waits, and
// its own result holds in the datapath until the output register frees.
// Reset (rst, synchronous) zeroes the accumulator and empties both sides;
// composing before any leaf composes over the all-zero accumulator.
module transform_chain_compose_top #(
  parameter int POS_FRAC_BITS = tcc_pkg::POS_FRAC_BITS_DEF,
  parameter int ROT_FRAC_BITS = tcc_pkg::ROT_FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               chain_start,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  input  logic signed [31:0] rot_x,
  input  logic signed [31:0] rot_y,
  input  logic signed [31:0] rot_z,
  input  logic signed [31:0] rot_w,
  input  logic [30:0]        scale_in,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_pos_x,
  output logic signed [31:0] out_pos_y,
  output logic signed [31:0] out_pos_z,
  output logic signed [31:0] out_rot_x,
  output logic signed [31:0] out_rot_y,
  output logic signed [31:0] out_rot_z,
  output logic signed [31:0] out_rot_w,
  output logic [30:0]        out_scale,
  output logic               overflow
);
  import tcc_pkg::*;

  cmd_t cmd;
  logic rst_acc;

  assign rst_acc = rst;

  tcc_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .chain_start (chain_start),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .cmd         (cmd)
  );

  cmd_t dp_cmd;

  always_comb begin
    dp_cmd = cmd;
    if (rst_acc) begin
      dp_cmd.capture = 1'b1;
      dp_cmd.acc     = 1'b1;
      dp_cmd.mul     = 1'b0;
      dp_cmd.finish  = 1'b0;
      dp_cmd.op      = OP_LOAD;
    end
  end

  tcc_datapath #(
    .POS_FRAC_BITS (POS_FRAC_BITS),
    .ROT_FRAC_BITS (ROT_FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .cmd       (dp_cmd),
    .pos_x     (rst_acc ? 32'sd0 : pos_x),
    .pos_y     (rst_acc ? 32'sd0 : pos_y),
    .pos_z     (rst_acc ? 32'sd0 : pos_z),
    .rot_x     (rst_acc ? 32'sd0 : rot_x),
    .rot_y     (rst_acc ? 32'sd0 : rot_y),
    .rot_z     (rst_acc ? 32'sd0 : rot_z),
    .rot_w     (rst_acc ? 32'sd0 : rot_w),
    .scale_in  (rst_acc ? 31'd0 : scale_in),
    .out_pos_x (out_pos_x),
    .out_pos_y (out_pos_y),
    .out_pos_z (out_pos_z),
    .out_rot_x (out_rot_x),
    .out_rot_y (out_rot_y),
    .out_rot_z (out_rot_z),
    .out_rot_w (out_rot_w),
    .out_scale (out_scale),
    .overflow  (overflow)
  );

endmodule

@@ rtl/core/tcc_ctrl.sv @@
// Sequencer that steps the datapath through one request.
module tcc_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          chain_start,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  output tcc_pkg::cmd_t cmd
);
  import tcc_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_ACC, ST_FIN} state_t;

  state_t state;
  op_t    op;
  logic   out_free;

  assign out_free    = !out_valid || !out_stall;
  assign in_stall    = (state != ST_IDLE);
  assign cmd.capture = (state == ST_IDLE) && in_valid;
  assign cmd.mul     = (state == ST_MUL);
  assign cmd.acc     = (state == ST_ACC);
  assign cmd.finish  = (state == ST_FIN) && out_free;
  assign cmd.op      = op;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      op        <= OP_LOAD;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && (state != ST_FIN)) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            op    <= chain_start ? OP_LOAD : OP_SCALE;
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          state <= ST_ACC;
        end
        ST_ACC: begin
          if (op == OP_LOAD || op == OP_PZ) begin
            state <= ST_FIN;
          end else begin
            op    <= op_t'(op + 4'd1);
            state <= ST_MUL;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

@@ rtl/core/tcc_datapath.sv @@
// Accumulator registers, four shared multipliers, summing and saturation.
module tcc_datapath #(
  parameter int POS_FRAC_BITS = tcc_pkg::POS_FRAC_BITS_DEF,
  parameter int ROT_FRAC_BITS = tcc_pkg::ROT_FRAC_BITS_DEF
) (
  input  logic               clk,
  input  tcc_pkg::cmd_t      cmd,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  input  logic signed [31:0] rot_x,
  input  logic signed [31:0] rot_y,
  input  logic signed [31:0] rot_z,
  input  logic signed [31:0] rot_w,
  input  logic [30:0]        scale_in,
  output logic signed [31:0] out_pos_x,
  output logic signed [31:0] out_pos_y,
  output logic signed [31:0] out_pos_z,
  output logic signed [31:0] out_rot_x,
  output logic signed [31:0] out_rot_y,
  output logic signed [31:0] out_rot_z,
  output logic signed [31:0] out_rot_w,
  output logic [30:0]        out_scale,
  output logic               overflow
);
  import tcc_pkg::*;

  localparam logic signed [66:0] S32_MAX = 67'sd2147483647;
  localparam logic signed [66:0] S32_MIN = -67'sd2147483648;
  localparam logic signed [66:0] SCL_MAX = 67'sd2147483647;
  localparam logic signed [66:0] RLIM    = 67'sd1 <<< ROT_FRAC_BITS;
  localparam logic signed [66:0] NRLIM   = -RLIM;

  typedef enum logic [1:0] {SAT_S32, SAT_ROT, SAT_SCL} sat_t;

  logic signed [31:0] pp [3];
  logic signed [31:0] pq [4];
  logic [30:0]        ps;
  logic signed [31:0] acc_pos [3];
  logic signed [31:0] acc_rot [4];
  logic [30:0]        acc_scale;
  logic signed [31:0] nq [3];
  logic signed [31:0] v [3];
  logic signed [31:0] t [3];
  logic signed [63:0] prod [4];
  logic               ov;

  logic signed [31:0] opa [4];
  logic signed [31:0] opb [4];
  logic               mneg [4];
  logic               pshift;
  logic               dbl;
  sat_t               skind;
  logic signed [66:0] addend;
  logic signed [66:0] sumv;
  logic signed [66:0] sumd;
  logic signed [66:0] term;
  logic signed [31:0] res;
  logic               sov;
  logic signed [31:0] ldrot [4];
  logic               ldov;

  logic signed [31:0] qx, qy, qz, qw, ax, ay, az, aw, psx;

  assign qx  = pq[0];
  assign qy  = pq[1];
  assign qz  = pq[2];
  assign qw  = pq[3];
  assign ax  = acc_rot[0];
  assign ay  = acc_rot[1];
  assign az  = acc_rot[2];
  assign aw  = acc_rot[3];
  assign psx = $signed({1'b0, ps});

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      opa[k]  = '0;
      opb[k]  = '0;
      mneg[k] = 1'b0;
    end
    pshift = 1'b0;
    dbl    = 1'b0;
    skind  = SAT_S32;
    addend = '0;
    case (cmd.op)
      OP_SCALE: begin
        opa[0] = psx; opb[0] = $signed({1'b0, acc_scale});
        pshift = 1'b1; skind = SAT_SCL;
      end
      OP_QX: begin
        opa[0] = qw; opb[0] = ax; opa[1] = qx; opb[1] = aw;
        opa[2] = qy; opb[2] = az; opa[3] = qz; opb[3] = ay; mneg[3] = 1'b1;
        skind = SAT_ROT;
      end
      OP_QY: begin
        opa[0] = qw; opb[0] = ay; opa[1] = qx; opb[1] = az; mneg[1] = 1'b1;
        opa[2] = qy; opb[2] = aw; opa[3] = qz; opb[3] = ax;
        skind = SAT_ROT;
      end
      OP_QZ: begin
        opa[0] = qw; opb[0] = az; opa[1] = qx; opb[1] = ay;
        opa[2] = qy; opb[2] = ax; mneg[2] = 1'b1; opa[3] = qz; opb[3] = aw;
        skind = SAT_ROT;
      end
      OP_QW: begin
        opa[0] = qw; opb[0] = aw; opa[1] = qx; opb[1] = ax; mneg[1] = 1'b1;
        opa[2] = qy; opb[2] = ay; mneg[2] = 1'b1;
        opa[3] = qz; opb[3] = az; mneg[3] = 1'b1;
        skind = SAT_ROT;
      end
      OP_VX: begin
        opa[0] = acc_pos[0]; opb[0] = psx; pshift = 1'b1;
      end
      OP_VY: begin
        opa[0] = acc_pos[1]; opb[0] = psx; pshift = 1'b1;
      end
      OP_VZ: begin
        opa[0] = acc_pos[2]; opb[0] = psx; pshift = 1'b1;
      end
      OP_TX: begin
        opa[0] = qy; opb[0] = v[2]; opa[1] = qz; opb[1] = v[1]; mneg[1] = 1'b1;
        dbl = 1'b1;
      end
      OP_TY: begin
        opa[0] = qz; opb[0] = v[0]; opa[1] = qx; opb[1] = v[2]; mneg[1] = 1'b1;
        dbl = 1'b1;
      end
      OP_TZ: begin
        opa[0] = qx; opb[0] = v[1]; opa[1] = qy; opb[1] = v[0]; mneg[1] = 1'b1;
        dbl = 1'b1;
      end
      OP_PX: begin
        opa[0] = qw; opb[0] = t[0]; opa[1] = qy; opb[1] = t[2];
        opa[2] = qz; opb[2] = t[1]; mneg[2] = 1'b1;
        addend = 67'(pp[0]) + 67'(v[0]);
      end
      OP_PY: begin
        opa[0] = qw; opb[0] = t[1]; opa[1] = qz; opb[1] = t[0];
        opa[2] = qx; opb[2] = t[2]; mneg[2] = 1'b1;
        addend = 67'(pp[1]) + 67'(v[1]);
      end
      OP_PZ: begin
        opa[0] = qw; opb[0] = t[2]; opa[1] = qx; opb[1] = t[1];
        opa[2] = qy; opb[2] = t[0]; mneg[2] = 1'b1;
        addend = 67'(pp[2]) + 67'(v[2]);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    sumv = addend;
    for (int k = 0; k < 4; k++) begin
      term = pshift ? 67'(prod[k] >>> POS_FRAC_BITS) : 67'(prod[k] >>> ROT_FRAC_BITS);
      sumv = mneg[k] ? sumv - term : sumv + term;
    end
    sumd = dbl ? (sumv <<< 1) : sumv;
    sov  = 1'b0;
    res  = sumd[31:0];
    case (skind)
      SAT_ROT: begin
        if (sumd > RLIM) begin
          res = RLIM[31:0]; sov = 1'b1;
        end else if (sumd < NRLIM) begin
          res = NRLIM[31:0]; sov = 1'b1;
        end
      end
      SAT_SCL: begin
        if (sumd > SCL_MAX) begin
          res = SCL_MAX[31:0]; sov = 1'b1;
        end else if (sumd < 0) begin
          res = '0; sov = 1'b1;
        end
      end
      default: begin
        if (sumd > S32_MAX) begin
          res = S32_MAX[31:0]; sov = 1'b1;
        end else if (sumd < S32_MIN) begin
          res = S32_MIN[31:0]; sov = 1'b1;
        end
      end
    endcase
  end

  always_comb begin
    ldov = 1'b0;
    for (int k = 0; k < 4; k++) begin
      ldrot[k] = pq[k];
      if (67'(pq[k]) > RLIM) begin
        ldrot[k] = RLIM[31:0]; ldov = 1'b1;
      end else if (67'(pq[k]) < NRLIM) begin
        ldrot[k] = NRLIM[31:0]; ldov = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      pp[0] <= pos_x; pp[1] <= pos_y; pp[2] <= pos_z;
      pq[0] <= rot_x; pq[1] <= rot_y; pq[2] <= rot_z; pq[3] <= rot_w;
      ps    <= scale_in;
    end
    if (cmd.mul) begin
      for (int k = 0; k < 4; k++) begin
        prod[k] <= opa[k] * opb[k];
      end
    end
    if (cmd.acc) begin
      case (cmd.op)
        OP_LOAD: begin
          for (int k = 0; k < 3; k++) begin
            acc_pos[k] <= pp[k];
          end
          for (int k = 0; k < 4; k++) begin
            acc_rot[k] <= ldrot[k];
          end
          acc_scale <= ps;
          ov        <= ldov;
        end
        OP_SCALE: begin acc_scale <= res[30:0]; ov <= sov; end
        OP_QX:    begin nq[0] <= res; ov <= ov | sov; end
        OP_QY:    begin nq[1] <= res; ov <= ov | sov; end
        OP_QZ:    begin nq[2] <= res; ov <= ov | sov; end
        OP_QW: begin
          acc_rot[0] <= nq[0]; acc_rot[1] <= nq[1]; acc_rot[2] <= nq[2];
          acc_rot[3] <= res; ov <= ov | sov;
        end
        OP_VX: begin v[0] <= res; ov <= ov | sov; end
        OP_VY: begin v[1] <= res; ov <= ov | sov; end
        OP_VZ: begin v[2] <= res; ov <= ov | sov; end
        OP_TX: begin t[0] <= res; ov <= ov | sov; end
        OP_TY: begin t[1] <= res; ov <= ov | sov; end
        OP_TZ: begin t[2] <= res; ov <= ov | sov; end
        OP_PX: begin acc_pos[0] <= res; ov <= ov | sov; end
        OP_PY: begin acc_pos[1] <= res; ov <= ov | sov; end
        OP_PZ: begin acc_pos[2] <= res; ov <= ov | sov; end
        default: begin
        end
      endcase
    end
    if (cmd.finish) begin
      out_pos_x <= acc_pos[0];
      out_pos_y <= acc_pos[1];
      out_pos_z <= acc_pos[2];
      out_rot_x <= acc_rot[0];
      out_rot_y <= acc_rot[1];
      out_rot_z <= acc_rot[2];
      out_rot_w <= acc_rot[3];
      out_scale <= acc_scale;
      overflow  <= ov;
    end
  end

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the transform chain composer: predicted chains vs DUT.
module testbench;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic               chain_start;
  logic signed [31:0] pos_x, pos_y, pos_z;
  logic signed [31:0] rot_x, rot_y, rot_z, rot_w;
  logic [30:0]        scale_in;
  logic               out_valid;
  logic               out_stall;
  logic signed [31:0] out_pos_x, out_pos_y, out_pos_z;
  logic signed [31:0] out_rot_x, out_rot_y, out_rot_z, out_rot_w;
  logic [30:0]        out_scale;
  logic               overflow;

  typedef struct packed {
    logic signed [31:0] px, py, pz;
    logic signed [31:0] qx, qy, qz, qw;
    logic [30:0]        sc;
    logic               ovf;
  } xform_t;

  localparam int  PFB      = tcc_pkg::POS_FRAC_BITS_DEF;
  localparam int  RFB      = tcc_pkg::ROT_FRAC_BITS_DEF;
  localparam longint RLIM  = longint'(1) << RFB;
  localparam longint S32MX = 64'sd2147483647;
  localparam longint S32MN = -64'sd2147483648;
  localparam int  WDOG_LIMIT = 2000;

  xform_t  expected_q[$];
  longint  acc_pos[3];
  longint  acc_rot[4];
  longint  acc_scl;
  int      mismatches;
  int      results_seen;
  int      idle_cycles;
  int      leaf_cnt, parent_cnt;

  transform_chain_compose_top DUT (.*);

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  function automatic longint clampv(longint x, longint lo, longint hi, ref bit ov);
    if (x < lo) begin ov = 1; return lo; end
    if (x > hi) begin ov = 1; return hi; end
    return x;
  endfunction

  function automatic longint qmul(longint a, longint b);
    return (a * b) >>> RFB;
  endfunction

  // compute the new accumulator for one request and queue it
  task automatic predict_compose(bit leaf, longint p[3], longint q[4], longint s);
    bit     ov;
    longint v[3], t[3], nq[4], ns, np[3];
    ov = 0;
    if (leaf) begin
      for (int i = 0; i < 3; i++) acc_pos[i] = p[i];
      for (int i = 0; i < 4; i++) acc_rot[i] = clampv(q[i], -RLIM, RLIM, ov);
      acc_scl = s;
    end else begin
      ns = clampv((s * acc_scl) >>> PFB, 0, S32MX, ov);
      nq[0] = qmul(q[3], acc_rot[0]) + qmul(q[0], acc_rot[3]) + qmul(q[1], acc_rot[2])
            - qmul(q[2], acc_rot[1]);
      nq[1] = qmul(q[3], acc_rot[1]) - qmul(q[0], acc_rot[2]) + qmul(q[1], acc_rot[3])
            + qmul(q[2], acc_rot[0]);
      nq[2] = qmul(q[3], acc_rot[2]) + qmul(q[0], acc_rot[1]) - qmul(q[1], acc_rot[0])
            + qmul(q[2], acc_rot[3]);
      nq[3] = qmul(q[3], acc_rot[3]) - qmul(q[0], acc_rot[0]) - qmul(q[1], acc_rot[1])
            - qmul(q[2], acc_rot[2]);
      for (int i = 0; i < 3; i++)
        v[i] = clampv((acc_pos[i] * s) >>> PFB, S32MN, S32MX, ov);
      t[0] = 2 * (qmul(q[1], v[2]) - qmul(q[2], v[1]));
      t[1] = 2 * (qmul(q[2], v[0]) - qmul(q[0], v[2]));
      t[2] = 2 * (qmul(q[0], v[1]) - qmul(q[1], v[0]));
      for (int i = 0; i < 3; i++) t[i] = clampv(t[i], S32MN, S32MX, ov);
      np[0] = p[0] + v[0] + qmul(q[3], t[0]) + qmul(q[1], t[2]) - qmul(q[2], t[1]);
      np[1] = p[1] + v[1] + qmul(q[3], t[1]) + qmul(q[2], t[0]) - qmul(q[0], t[2]);
      np[2] = p[2] + v[2] + qmul(q[3], t[2]) + qmul(q[0], t[1]) - qmul(q[1], t[0]);
      for (int i = 0; i < 3; i++) acc_pos[i] = clampv(np[i], S32MN, S32MX, ov);
      for (int i = 0; i < 4; i++) acc_rot[i] = clampv(nq[i], -RLIM, RLIM, ov);
      acc_scl = ns;
    end
    expected_q.push_back('{acc_pos[0][31:0], acc_pos[1][31:0], acc_pos[2][31:0],
                           acc_rot[0][31:0], acc_rot[1][31:0], acc_rot[2][31:0],
                           acc_rot[3][31:0], acc_scl[30:0], ov});
  endtask

  task automatic send_request(bit leaf, logic signed [31:0] px, logic signed [31:0] py,
                              logic signed [31:0] pz, logic signed [31:0] qx,
                              logic signed [31:0] qy, logic signed [31:0] qz,
                              logic signed [31:0] qw, logic [30:0] s);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1;
    chain_start <= leaf;
    pos_x <= px; pos_y <= py; pos_z <= pz;
    rot_x <= qx; rot_y <= qy; rot_z <= qz; rot_w <= qw;
    scale_in <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_compose(leaf, '{longint'(px), longint'(py), longint'(pz)},
                    '{longint'(qx), longint'(qy), longint'(qz), longint'(qw)},
                    longint'(s));
    if (leaf) leaf_cnt++; else parent_cnt++;
  endtask

  function automatic logic signed [31:0] rand_rot();
    case ($urandom_range(0, 5))
      0: return 32'sh4000_0000;
      1: return -32'sh4000_0000;
      2: return $urandom();
      default: return $signed($urandom_range(0, 32'h8000_0000)) - 32'sh4000_0000;
    endcase
  endfunction

  function automatic logic signed [31:0] rand_pos();
    case ($urandom_range(0, 4))
      0: return $urandom();
      1: return $signed(32'h7fff_ffff) - $urandom_range(0, 3);
      default: return $signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
    endcase
  endfunction

  function automatic logic [30:0] rand_scale();
    case ($urandom_range(0, 4))
      0: return 31'($urandom());
      1: return 31'h1_0000;
      default: return 31'($urandom_range(32'h0000_4000, 32'h0004_0000));
    endcase
  endfunction

  task automatic test_leaf_extremes();
    send_request(0, 32'sh0001_0000, 0, 0, 0, 0, 0, 32'sh4000_0000, 31'h1_0000);
    send_request(1, 32'sh7fff_ffff, -32'sh8000_0000, 0, 32'sh4000_0000,
                 -32'sh4000_0000, 0, 0, 31'h7fff_ffff);
    send_request(1, 0, 0, 0, 32'sh7fff_ffff, -32'sh8000_0000, 32'sh4000_0001,
                 -32'sh4000_0001, 0);
    send_request(1, -1, 1, 32'sh1234_5678, 0, 0, 0, 32'sh4000_0000, 31'h1_0000);
  endtask

  task automatic test_compose_directed();
    send_request(0, 32'sh0002_0000, 0, 0, 0, 0, 32'sh2d41_3ccc, 32'sh2d41_3ccc, 31'h1_0000);
    send_request(0, 0, 0, 0, 32'sh4000_0000, 0, 0, 0, 31'h2_0000);
    send_request(0, 32'sh7fff_ffff, 32'sh7fff_ffff, -32'sh8000_0000, 0, 0, 0,
                 32'sh4000_0000, 31'h7fff_ffff);
    send_request(1, 32'sh7fff_0000, -32'sh7fff_0000, 32'sh4000_0000, 32'sh2000_0000,
                 32'sh2000_0000, 32'sh2000_0000, 32'sh2000_0000, 31'h7fff_ffff);
    send_request(0, 32'sh7fff_ffff, 0, 0, 32'sh4000_0000, 32'sh4000_0000,
                 32'sh4000_0000, 32'sh4000_0000, 31'h7fff_ffff);
    send_request(0, 0, 0, 0, -32'sh4000_0000, -32'sh4000_0000, -32'sh4000_0000,
                 -32'sh4000_0000, 0);
    send_request(0, -32'sh8000_0000, -1, 1, 32'sh7fff_ffff, -32'sh8000_0000,
                 32'sh7fff_ffff, -32'sh8000_0000, 31'h1);
  endtask

  task automatic test_random_chains();
    int sent, depth;
    sent = 0;
    while (sent < 800) begin
      depth = $urandom_range(0, 6);
      send_request(($urandom_range(0, 9) != 0), rand_pos(), rand_pos(), rand_pos(),
                   rand_rot(), rand_rot(), rand_rot(), rand_rot(), rand_scale());
      sent++;
      for (int d = 0; d < depth; d++) begin
        send_request(0, rand_pos(), rand_pos(), rand_pos(), rand_rot(), rand_rot(),
                     rand_rot(), rand_rot(), rand_scale());
        sent++;
      end
    end
  endtask

  // result checker
  initial begin
    xform_t got, want;
    int     stall_left;
    out_stall  = 0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        got = '{out_pos_x, out_pos_y, out_pos_z, out_rot_x, out_rot_y, out_rot_z,
                out_rot_w, out_scale, overflow};
        results_seen++;
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("ERROR: unexpected result %p", got);
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("ERROR: result %0d mismatch\n  expected %p\n  actual   %p",
                       results_seen, want, got);
          end
        end
        stall_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
      end
      if (stall_left > 0) begin
        out_stall <= 1;
        stall_left--;
      end else begin
        out_stall <= 0;
      end
    end
  end

  // watchdog
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WDOG_LIMIT) begin
        $display("Watchdog: no progress, %0d results outstanding", expected_q.size());
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    rst = 1;
    in_valid = 0;
    chain_start = 0;
    pos_x = 0; pos_y = 0; pos_z = 0;
    rot_x = 0; rot_y = 0; rot_z = 0; rot_w = 0;
    scale_in = 0;
    mismatches = 0;
    results_seen = 0;
    leaf_cnt = 0;
    parent_cnt = 0;
    for (int i = 0; i < 3; i++) acc_pos[i] = 0;
    for (int i = 0; i < 4; i++) acc_rot[i] = 0;
    acc_scl = 0;
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_leaf_extremes();
    test_compose_directed();
    test_random_chains();
    in_valid <= 0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("Covered %0d leaf loads and %0d parent compositions, %0d results checked.",
             leaf_cnt, parent_cnt, results_seen);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
